### design/lstm_gate_preactivation_macros.svh
// Assertion macros used by the gate pre-activation design file.
`ifndef LSTM_GATE_PREACTIVATION_MACROS_SVH
`define LSTM_GATE_PREACTIVATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LGP_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LGP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lgp_pkg.sv
// Package: types, codes and constants of the gate pre-activation engine.
`default_nettype none

package lgp_pkg;

    // Default sizes
    localparam int MAX_HIDDEN_DEF  = 16;
    localparam int MAX_COLUMNS_DEF = 64;

    // Saturation to signed 16 bits
    localparam int CLIP_BITS = 15;

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 4;
    localparam int COLF_W  = 6;
    localparam int VAL_W   = 16;
    localparam int BIAS_W  = 32;
    localparam int ACC_W   = 32;
    localparam int CCNT_W  = 7;
    localparam int HCFG_W  = 5;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REC_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IN_WEIGHT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HIDDEN     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RUN        = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_INPUT    = 2'd3;

    // Configuration reset values
    localparam logic [SHIFT_W-1:0] NORM_SHIFT_RST   = 5'd11;
    localparam logic [HCFG_W-1:0]  HIDDEN_COUNT_RST = 5'd16;
    localparam logic [CCNT_W-1:0]  COLUMN_COUNT_RST = 7'd64;
    localparam logic               USE_INPUT_RST    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### design/lstm_gate_preactivation.sv
// LSTM gate pre-activation engine: one shared 16x16 multiplier under a small sequencer.
// Load items are taken while idle and leave the engine idle. A run holds off the next item
// until its final column is emitted, and a stall on the result side delays that further.
// Per column: nhid+1 multiplier issues, a pipeline drain, a round and an emit.
// Reset clears the sequencer and the result valid flag and loads the configuration defaults;
// weight, bias and hidden stores hold garbage until written.
`default_nettype none
`include "lstm_gate_preactivation_macros.svh"

module lstm_gate_preactivation #(
    parameter int MAX_HIDDEN  = lgp_pkg::MAX_HIDDEN_DEF,
    parameter int MAX_COLUMNS = lgp_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // item channel
    input  wire logic                                   item_valid,
    output logic                                        item_stall,
    input  wire logic        [lgp_pkg::CMD_W-1:0]       command,
    input  wire logic        [lgp_pkg::ROW_W-1:0]       row,
    input  wire logic        [lgp_pkg::COLF_W-1:0]      column,
    input  wire logic signed [lgp_pkg::VAL_W-1:0]       value,
    input  wire logic signed [lgp_pkg::BIAS_W-1:0]      bias_value,
    // result channel
    output logic                                        result_valid,
    input  wire logic                                   result_stall,
    output logic             [lgp_pkg::COLF_W-1:0]      column_index,
    output logic signed      [lgp_pkg::VAL_W-1:0]       preactivation,
    output logic                                        last,
    // configuration channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [lgp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [lgp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int HID_W     = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int HC_RAW    = $clog2(MAX_HIDDEN + 1);
    localparam int HC_W      = (HC_RAW > lgp_pkg::HCFG_W) ? HC_RAW : lgp_pkg::HCFG_W;
    localparam int COL_DEPTH = 2 ** COL_W;
    localparam int REC_DEPTH = MAX_HIDDEN * COL_DEPTH;
    localparam int VW        = lgp_pkg::VAL_W;
    localparam int AW        = lgp_pkg::ACC_W;
    localparam int RW        = lgp_pkg::ACC_W + 1;
    localparam int CW        = lgp_pkg::CCNT_W;

    localparam logic signed [RW-1:0] CLIP_HI = RW'((2 ** lgp_pkg::CLIP_BITS) - 1);
    localparam logic signed [RW-1:0] CLIP_LO = -RW'(2 ** lgp_pkg::CLIP_BITS);

    // configuration registers
    logic [lgp_pkg::SHIFT_W-1:0] norm_shift_reg;
    logic [lgp_pkg::HCFG_W-1:0]  hidden_count_reg;
    logic [CW-1:0]               column_count_reg;
    logic                        use_input_reg;

    lgp_pkg::state_t state_reg, state_next;

    logic [HC_W-1:0]         step_reg;
    logic [CW-1:0]           col_cnt_reg;
    logic signed [VW-1:0]    sample_reg;

    // stores
    logic signed [VW-1:0]    rec_mem  [REC_DEPTH];
    logic signed [VW-1:0]    iw_mem   [COL_DEPTH];
    logic signed [AW-1:0]    bias_mem [COL_DEPTH];
    logic signed [VW-1:0]    hid_mem  [2 ** HID_W];

    logic signed [VW-1:0]    rec_rd_reg;
    logic signed [VW-1:0]    iw_rd_reg;
    logic signed [AW-1:0]    bias_rd_reg;
    logic signed [VW-1:0]    hid_rd_reg;

    // multiply-accumulate pipeline
    logic                    p1_valid_reg, p1_first_reg;
    logic                    p2_valid_reg, p2_first_reg;
    logic signed [AW-1:0]    prod_reg;
    logic signed [AW-1:0]    bias_p2_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [RW-1:0]    round_reg;

    logic                    result_valid_reg;
    logic [lgp_pkg::COLF_W-1:0] column_index_reg;
    logic signed [VW-1:0]    preact_reg;
    logic                    last_reg;

    // derived control
    logic [HC_W-1:0]         hid_ext;
    logic [HC_W-1:0]         nhid;
    logic [CW-1:0]           ncols;
    logic                    item_accept;
    logic                    run_start;
    logic                    issue;
    logic                    result_load;
    logic                    last_next;
    logic                    step_first;
    logic [HC_W-1:0]         step_prev;
    logic [HID_W-1:0]        hid_row;
    logic [COL_W-1:0]        col_idx;
    logic                    row_ok, col_ok;
    logic [HID_W-1:0]        wr_row;
    logic [COL_W-1:0]        wr_col;
    logic signed [VW-1:0]    mul_a, mul_b;
    logic signed [RW-1:0]    round_add;
    logic signed [RW-1:0]    shifted;
    logic signed [VW-1:0]    preact_next;

    assign hid_ext = HC_W'(hidden_count_reg);
    assign nhid    = (hid_ext > HC_W'(MAX_HIDDEN)) ? HC_W'(MAX_HIDDEN) : hid_ext;
    assign ncols   = (column_count_reg > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                           : column_count_reg;

    assign item_accept = item_valid && !item_stall;
    assign run_start   = item_accept && (command == lgp_pkg::CMD_RUN) && (ncols != '0);
    assign last_next   = ((col_cnt_reg + CW'(1)) == ncols);

    assign step_first = (step_reg == '0);
    assign step_prev  = step_reg - HC_W'(1);
    assign hid_row    = HID_W'(step_prev);
    assign col_idx    = col_cnt_reg[COL_W-1:0];

    assign row_ok = ({28'd0, row} < 32'(MAX_HIDDEN));
    assign col_ok = ({1'b0, column} < CW'(MAX_COLUMNS));
    assign wr_row = HID_W'(row);
    assign wr_col = COL_W'(column);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_shift_reg   <= lgp_pkg::NORM_SHIFT_RST;
            hidden_count_reg <= lgp_pkg::HIDDEN_COUNT_RST;
            column_count_reg <= lgp_pkg::COLUMN_COUNT_RST;
            use_input_reg    <= lgp_pkg::USE_INPUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lgp_pkg::CFG_NORM_SHIFT:   norm_shift_reg   <= cfg_data[lgp_pkg::SHIFT_W-1:0];
                lgp_pkg::CFG_HIDDEN_COUNT: hidden_count_reg <= cfg_data[lgp_pkg::HCFG_W-1:0];
                lgp_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[CW-1:0];
                lgp_pkg::CFG_USE_INPUT:    use_input_reg    <= cfg_data[0];
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lgp_pkg::ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = lgp_pkg::ST_ISSUE;
                end
            end
            lgp_pkg::ST_ISSUE:
            begin
                if (step_reg == nhid)
                begin
                    state_next = lgp_pkg::ST_DRAIN;
                end
            end
            lgp_pkg::ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = lgp_pkg::ST_ROUND;
                end
            end
            lgp_pkg::ST_ROUND:
            begin
                state_next = lgp_pkg::ST_EMIT;
            end
            lgp_pkg::ST_EMIT:
            begin
                if (result_load)
                begin
                    state_next = last_next ? lgp_pkg::ST_IDLE : lgp_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = lgp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = 1'b1;
        cfg_ready   = 1'b0;
        issue       = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            lgp_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cfg_ready  = 1'b1;
            end
            lgp_pkg::ST_ISSUE:
            begin
                issue = 1'b1;
            end
            lgp_pkg::ST_EMIT:
            begin
                // take the result register once it is empty or being drained
                result_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            col_cnt_reg <= '0;
        end
        else if (run_start)
        begin
            step_reg    <= '0;
            col_cnt_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                step_reg <= (step_reg == nhid) ? '0 : step_reg + HC_W'(1);
            end
            if (result_load)
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            sample_reg <= value;
        end
    end

    // ---------------- stores ----------------
    always_ff @(posedge clk)
    begin
        if (item_accept && (command == lgp_pkg::CMD_REC_WEIGHT) && row_ok && col_ok)
        begin
            rec_mem[{wr_row, wr_col}] <= value;
        end
        rec_rd_reg <= rec_mem[{hid_row, col_idx}];
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && (command == lgp_pkg::CMD_IN_WEIGHT) && col_ok)
        begin
            iw_mem[wr_col] <= value;
        end
        iw_rd_reg <= iw_mem[col_idx];
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && (command == lgp_pkg::CMD_IN_WEIGHT) && col_ok)
        begin
            bias_mem[wr_col] <= bias_value;
        end
        bias_rd_reg <= bias_mem[col_idx];
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && (command == lgp_pkg::CMD_HIDDEN) && row_ok)
        begin
            hid_mem[wr_row] <= value;
        end
        hid_rd_reg <= hid_mem[hid_row];
    end

    // ---------------- shared multiplier and accumulator ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_first_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_first_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p1_first_reg <= issue && step_first;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
        end
    end

    // first step of a column multiplies the sample by the input weight
    assign mul_a = p1_first_reg ? sample_reg : hid_rd_reg;
    assign mul_b = p1_first_reg ? iw_rd_reg  : rec_rd_reg;

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (p1_first_reg)
        begin
            bias_p2_reg <= bias_rd_reg;
        end
        if (p2_valid_reg)
        begin
            if (p2_first_reg)
            begin
                acc_reg <= bias_p2_reg + (use_input_reg ? prod_reg : '0);
            end
            else
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    // ---------------- round, shift, saturate ----------------
    assign round_add = (norm_shift_reg != '0)
                     ? (RW'(1) <<< (norm_shift_reg - lgp_pkg::SHIFT_W'(1))) : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == lgp_pkg::ST_ROUND)
        begin
            round_reg <= {acc_reg[AW-1], acc_reg} + round_add;
        end
    end

    assign shifted = round_reg >>> norm_shift_reg;

    always_comb
    begin
        priority if (shifted > CLIP_HI)
        begin
            preact_next = VW'(CLIP_HI);
        end
        else if (shifted < CLIP_LO)
        begin
            preact_next = VW'(CLIP_LO);
        end
        else
        begin
            preact_next = VW'(shifted);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            column_index_reg <= lgp_pkg::COLF_W'(col_cnt_reg);
            preact_reg       <= preact_next;
            last_reg         <= last_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign column_index  = column_index_reg;
    assign preactivation = preact_reg;
    assign last          = last_reg;

    // ---------------- assertions ----------------
    `LGP_ASSERT_NOW(a_idle_pipe_empty, clk, rst_n,
        state_reg == lgp_pkg::ST_IDLE, !p1_valid_reg && !p2_valid_reg,
        "MAC pipeline busy while idle")
    `LGP_ASSERT_NOW(a_col_in_range, clk, rst_n,
        state_reg != lgp_pkg::ST_IDLE, col_cnt_reg < ncols,
        "column counter beyond column count during a run")
    `LGP_ASSERT_NEXT(a_last_ends_run, clk, rst_n,
        result_load && last_next, state_reg == lgp_pkg::ST_IDLE,
        "run continues after its final column")

endmodule

`default_nettype wire
